// File: src/chipset_index_regs_shadow_ctrl_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chipset index register / shadow control block
// Shared immediate-style wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef CHIPSET_INDEX_REGS_SHADOW_CTRL_MACROS_SVH
`define CHIPSET_INDEX_REGS_SHADOW_CTRL_MACROS_SVH

// same-cycle implication
`define CIRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CIRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/cirs_pkg.sv
// ----------------------------------------------------------------------------
// cirs_pkg
// Codes, constants and register reset values for the index/shadow block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cirs_pkg;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PORT_INDEX = 2'd0,
      PORT_DATA  = 2'd1,
      PORT_A20   = 2'd2,
      PORT_RESET = 2'd3
   } port_type;

   localparam logic [7:0] REG_MASKED     = 8'd5;   // register with sticky bit 4
   localparam logic [7:0] MASKED_KEEP    = 8'h10;
   localparam logic [7:0] MASKED_WRITE   = 8'hef;
   localparam logic [7:0] SHADOW_FIRST   = 8'h0d;
   localparam int         SHADOW_COUNT   = 6;
   localparam int         SEG_PER_REG    = 4;
   localparam int         SEG_COUNT      = SHADOW_COUNT * SEG_PER_REG;
   localparam int         BIOS_SEG_FIRST = 16;     // segment at 0xE0000
   localparam logic [7:0] DATA_NONE      = 8'hff;  // read of A20 / reset port
   localparam logic [7:0] DATA_OUTSIDE   = 8'h00;  // data read past the file

   // reset contents of the register file
   function automatic logic [7:0] reg_reset_value(input logic [7:0] idx);
      logic [7:0] val;
      case (idx)
         8'd0:    val = 8'h90;
         8'd1:    val = 8'hff;
         8'd2:    val = 8'h8a;
         8'd3:    val = 8'h88;
         8'd6:    val = 8'h1b;
         8'd8:    val = 8'h38;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// File: src/cirs_ram.sv
// ----------------------------------------------------------------------------
// cirs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cirs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 37
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/chipset_index_regs_shadow_ctrl.sv
// ----------------------------------------------------------------------------
// chipset_index_regs_shadow_ctrl
// A beat's result passes the stage 1 register and the result register before it strobes.
// Throughput: one beat per cycle; busy is never raised, no backpressure.
// Reset: synchronous, active high; index clears, register file reads back
// its power-on values at once (per-entry valid bits), pipeline empties.
// Results cannot be stalled: rsp_strobe marks each one for a single cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chipset_index_regs_shadow_ctrl
   import cirs_pkg::*;
#(
   parameter int LAST_WRITABLE = 36
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [1:0]  req_port_offset,
   input  logic [7:0]  req_wdata,
   input  logic        req_a20_alt_now,
   // result channel
   output logic        rsp_strobe,
   output logic [7:0]  rsp_rdata,
   output logic [23:0] rsp_int_read_mask,
   output logic [23:0] rsp_int_write_mask,
   output logic        rsp_bios_shadow_read,
   output logic        rsp_bios_shadow_write,
   output logic        rsp_a20_enable_req,
   output logic        rsp_a20_disable_req,
   output logic        rsp_cpu_reset_req
);

`include "chipset_index_regs_shadow_ctrl_macros.svh"

   // File geometry: entries 0..LAST_WRITABLE, entry 0 read-only.
   localparam int         FILE_DEPTH = LAST_WRITABLE + 1;
   localparam int         ADDR_W     = $clog2(FILE_DEPTH);
   localparam logic [7:0] LAST_IDX   = 8'(LAST_WRITABLE);

   // Every beat is taken the cycle it arrives.
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // -------------------------------------------------------------------------
   // Stage 0: decode the incoming beat against the current index
   // -------------------------------------------------------------------------
   logic [7:0]            index_ff, index_in;
   logic                  in_file;     // index points inside the file
   logic                  file_wr;     // data-port write that lands
   logic [7:0]            file_wdata;
   logic [ADDR_W-1:0]     addr;

   assign in_file = (index_ff <= LAST_IDX);
   assign addr    = index_ff[ADDR_W-1:0];

   always_comb begin
      index_in   = index_ff;
      file_wr    = 1'b0;
      file_wdata = req_wdata;
      if (accept && req_op == OP_WRITE) begin
         case (port_type'(req_port_offset))
            PORT_INDEX: index_in = req_wdata;
            PORT_DATA:  file_wr  = in_file && (index_ff != 8'd0);
            default:    ;
         endcase
      end
      // bit 4 of register 5 is sticky; it is zero out of reset so it stays zero
      if (index_ff == REG_MASKED) begin
         file_wdata = (req_wdata & MASKED_WRITE) & ~MASKED_KEEP;
      end
   end

   // -------------------------------------------------------------------------
   // Register file: RAM plus per-entry valid bits. An entry never written
   // reads as its power-on value.
   // -------------------------------------------------------------------------
   logic [FILE_DEPTH-1:0] written_ff, written_in;
   logic [7:0]            ram_rdata;
   logic                  ram_rd;

   assign ram_rd = accept && in_file;

   cirs_ram #(
      .WIDTH(8),
      .DEPTH(FILE_DEPTH)
   ) u_file (
      .clock   (clock),
      .wr_en   (file_wr),
      .wr_addr (addr),
      .wr_data (file_wdata),
      .rd_en   (ram_rd),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      written_in = written_ff;
      if (file_wr) begin
         written_in[addr] = 1'b1;
      end
   end

   // Shadow control registers 0x0d..0x12 kept in flops as well, so the
   // segment masks decode every cycle without a RAM port.
   logic [7:0] shadow_ff [SHADOW_COUNT];
   logic [7:0] shadow_in [SHADOW_COUNT];

   always_comb begin
      for (int r = 0; r < SHADOW_COUNT; r++) begin
         shadow_in[r] = shadow_ff[r];
         if (file_wr && index_ff == SHADOW_FIRST + 8'(r)) begin
            shadow_in[r] = file_wdata;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1 register: beat context, waiting on the RAM read data
   // -------------------------------------------------------------------------
   logic       s1_valid_ff;
   op_type     s1_op_ff;
   port_type   s1_port_ff;
   logic [7:0] s1_index_ff;
   logic       s1_in_file_ff;
   logic       s1_written_ff;
   logic [7:0] s1_reset_val_ff;
   logic       s1_alt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= '0;
         written_ff  <= '0;
         s1_valid_ff <= 1'b0;
         for (int r = 0; r < SHADOW_COUNT; r++) begin
            shadow_ff[r] <= reg_reset_value(SHADOW_FIRST + 8'(r));
         end
      end else begin
         index_ff    <= index_in;
         written_ff  <= written_in;
         s1_valid_ff <= accept;
         for (int r = 0; r < SHADOW_COUNT; r++) begin
            shadow_ff[r] <= shadow_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff        <= op_type'(req_op);
         s1_port_ff      <= port_type'(req_port_offset);
         s1_index_ff     <= index_ff;
         s1_in_file_ff   <= in_file;
         s1_written_ff   <= in_file && written_ff[addr];
         s1_reset_val_ff <= reg_reset_value(index_ff);
         s1_alt_ff       <= req_a20_alt_now;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1 logic: read mux, request pulses, segment decode
   // -------------------------------------------------------------------------
   logic [7:0]  rdata_in;
   logic        a20_en_in, a20_dis_in, cpu_rst_in;
   logic [23:0] rmask_in, wmask_in;

   always_comb begin
      rdata_in   = 8'h00;
      a20_en_in  = 1'b0;
      a20_dis_in = 1'b0;
      cpu_rst_in = 1'b0;
      if (s1_op_ff == OP_WRITE) begin
         if (s1_port_ff == PORT_A20) begin
            a20_dis_in = s1_alt_ff;
         end
      end else begin
         case (s1_port_ff)
            PORT_INDEX: rdata_in = s1_index_ff;
            PORT_DATA: begin
               if (!s1_in_file_ff) begin
                  rdata_in = DATA_OUTSIDE;
               end else if (s1_written_ff) begin
                  rdata_in = ram_rdata;
               end else begin
                  rdata_in = s1_reset_val_ff;
               end
            end
            PORT_A20: begin
               rdata_in  = DATA_NONE;
               a20_en_in = ~s1_alt_ff;
            end
            PORT_RESET: begin
               rdata_in   = DATA_NONE;
               cpu_rst_in = 1'b1;
            end
            default: rdata_in = DATA_NONE;
         endcase
      end
   end

   // code bit 1 -> internal read, bit 0 -> internal write, 2 bits per segment
   always_comb begin
      for (int r = 0; r < SHADOW_COUNT; r++) begin
         for (int s = 0; s < SEG_PER_REG; s++) begin
            rmask_in[r*SEG_PER_REG+s] = shadow_ff[r][2*s+1];
            wmask_in[r*SEG_PER_REG+s] = shadow_ff[r][2*s];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result register
   // -------------------------------------------------------------------------
   logic        rsp_strobe_ff;
   logic [7:0]  rsp_rdata_ff;
   logic [23:0] rmask_ff, wmask_ff;
   logic        bios_rd_ff, bios_wr_ff;
   logic        a20_en_ff, a20_dis_ff, cpu_rst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         a20_en_ff     <= 1'b0;
         a20_dis_ff    <= 1'b0;
         cpu_rst_ff    <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
         a20_en_ff     <= s1_valid_ff & a20_en_in;
         a20_dis_ff    <= s1_valid_ff & a20_dis_in;
         cpu_rst_ff    <= s1_valid_ff & cpu_rst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_rdata_ff <= rdata_in;
         rmask_ff     <= rmask_in;
         wmask_ff     <= wmask_in;
         bios_rd_ff   <= |rmask_in[SEG_COUNT-1:BIOS_SEG_FIRST];
         bios_wr_ff   <= |wmask_in[SEG_COUNT-1:BIOS_SEG_FIRST];
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_rdata             = rsp_rdata_ff;
   assign rsp_int_read_mask     = rmask_ff;
   assign rsp_int_write_mask    = wmask_ff;
   assign rsp_bios_shadow_read  = bios_rd_ff;
   assign rsp_bios_shadow_write = bios_wr_ff;
   assign rsp_a20_enable_req    = a20_en_ff;
   assign rsp_a20_disable_req   = a20_dis_ff;
   assign rsp_cpu_reset_req     = cpu_rst_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `CIRS_ASSERT_NEXT(a_two_cycle_latency, clock, reset, accept, ##1 rsp_strobe, "result beat missing two cycles after accept")
   `CIRS_ASSERT_NOW(a_pulses_need_strobe, clock, reset, !rsp_strobe, !rsp_a20_enable_req && !rsp_a20_disable_req && !rsp_cpu_reset_req, "request pulse without a result beat")
   `CIRS_ASSERT_NOW(a_a20_exclusive, clock, reset, rsp_a20_enable_req, !rsp_a20_disable_req && !rsp_cpu_reset_req, "conflicting request pulses")
   `CIRS_ASSERT_NOW(a_reset_port_reads_ff, clock, reset, rsp_cpu_reset_req, rsp_rdata == DATA_NONE, "reset port read returned wrong data")
   `CIRS_ASSERT_NEXT(a_reg0_read_only, clock, reset, file_wr, $past(index_ff) != 8'd0, "write landed on read-only register 0")

endmodule

// File: tb/chipset_index_regs_shadow_ctrl_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chipset_index_regs_shadow_ctrl_tb
// Self-checking bench for the index/data register window with shadow decode.
// A queue of bus accesses feeds a falling-edge driver; every accepted beat
// is run through a local register-window predictor, and the strobed results
// are compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module chipset_index_regs_shadow_ctrl_tb;
   import cirs_pkg::*;

   localparam int LAST_WRITABLE = 36;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_BEATS  = 275;     // per idling phase
   localparam int REPORT_LIMIT  = 10;

   // register indexes with non-zero power-on values, plus edges of the file
   localparam logic [7:0] REG_ID      = 8'd0;  // read-only
   localparam logic [7:0] REG_CFG1    = 8'd1;
   localparam logic [7:0] REG_CFG2    = 8'd2;
   localparam logic [7:0] REG_CFG3    = 8'd3;
   localparam logic [7:0] REG_CFG6    = 8'd6;
   localparam logic [7:0] REG_CFG8    = 8'd8;
   localparam logic [7:0] REG_LAST    = 8'(LAST_WRITABLE);
   localparam logic [7:0] REG_PAST    = 8'(LAST_WRITABLE + 1);
   localparam logic [7:0] REG_TOP     = 8'hff;
   localparam logic [7:0] SHADOW_LAST = 8'(SHADOW_FIRST + SHADOW_COUNT - 1);

   typedef struct {
      op_type     op;
      port_type   port;
      logic [7:0] wdata;
      logic       alt;
   } window_beat_type;

   typedef struct {
      logic [7:0]  rdata;
      logic [23:0] rd_mask;
      logic [23:0] wr_mask;
      logic        bios_rd;
      logic        bios_wr;
      logic        a20_en;
      logic        a20_dis;
      logic        cpu_rst;
   } window_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_op;
   logic [1:0]  req_port_offset;
   logic [7:0]  req_wdata;
   logic        req_a20_alt_now;
   logic        rsp_strobe;
   logic [7:0]  rsp_rdata;
   logic [23:0] rsp_int_read_mask;
   logic [23:0] rsp_int_write_mask;
   logic        rsp_bios_shadow_read;
   logic        rsp_bios_shadow_write;
   logic        rsp_a20_enable_req;
   logic        rsp_a20_disable_req;
   logic        rsp_cpu_reset_req;

   // predictor state: index register and register file
   logic [7:0] chip_index;
   logic [7:0] chip_regs [0:LAST_WRITABLE];

   window_beat_type   pending_beats[$];
   window_result_type expected_results[$];

   int  beats_queued   = 0;
   int  beats_accepted = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  idle_pct       = 14;
   logic beat_taken    = 1'b0;

   chipset_index_regs_shadow_ctrl #(
      .LAST_WRITABLE(LAST_WRITABLE)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_port_offset       (req_port_offset),
      .req_wdata             (req_wdata),
      .req_a20_alt_now       (req_a20_alt_now),
      .rsp_strobe            (rsp_strobe),
      .rsp_rdata             (rsp_rdata),
      .rsp_int_read_mask     (rsp_int_read_mask),
      .rsp_int_write_mask    (rsp_int_write_mask),
      .rsp_bios_shadow_read  (rsp_bios_shadow_read),
      .rsp_bios_shadow_write (rsp_bios_shadow_write),
      .rsp_a20_enable_req    (rsp_a20_enable_req),
      .rsp_a20_disable_req   (rsp_a20_disable_req),
      .rsp_cpu_reset_req     (rsp_cpu_reset_req)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("chipset_index_regs_shadow_ctrl regression: fail");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Predictor. Applies one accepted access to the local copy of the window
   // and returns what the block should report for it. Masks reflect the file
   // after this access's own update.
   // --------------------------------------------------------------------------
   function automatic window_result_type shadow_window_predict(window_beat_type b);
      window_result_type res;
      logic [7:0]        code_byte;
      res = '{rdata: 8'h00, rd_mask: 24'h0, wr_mask: 24'h0, bios_rd: 1'b0,
              bios_wr: 1'b0, a20_en: 1'b0, a20_dis: 1'b0, cpu_rst: 1'b0};
      if (b.op == OP_WRITE) begin
         case (b.port)
            PORT_INDEX: chip_index = b.wdata;
            PORT_DATA: begin
               // register 0 and anything past the file ignore writes
               if (chip_index != REG_ID && chip_index <= REG_LAST) begin
                  if (chip_index == REG_MASKED)
                     chip_regs[chip_index] = (chip_regs[chip_index] & MASKED_KEEP) |
                                             (b.wdata & MASKED_WRITE);
                  else
                     chip_regs[chip_index] = b.wdata;
               end
            end
            PORT_A20: res.a20_dis = b.alt;
            default: ;  // write to reset port does nothing
         endcase
      end else begin
         res.rdata = DATA_NONE;
         case (b.port)
            PORT_INDEX: res.rdata = chip_index;
            PORT_DATA:  res.rdata = (chip_index <= REG_LAST) ? chip_regs[chip_index]
                                                              : DATA_OUTSIDE;
            PORT_A20:   res.a20_en = !b.alt;
            default:    res.cpu_rst = 1'b1;
         endcase
      end
      // two bits per segment: bit 1 = internal read, bit 0 = internal write
      for (int r = 0; r < SHADOW_COUNT; r++) begin
         code_byte = chip_regs[SHADOW_FIRST + r];
         for (int s = 0; s < SEG_PER_REG; s++) begin
            res.rd_mask[r * SEG_PER_REG + s] = code_byte[2 * s + 1];
            res.wr_mask[r * SEG_PER_REG + s] = code_byte[2 * s];
         end
      end
      res.bios_rd = |res.rd_mask[SEG_COUNT-1:BIOS_SEG_FIRST];
      res.bios_wr = |res.wr_mask[SEG_COUNT-1:BIOS_SEG_FIRST];
      return res;
   endfunction

   // --------------------------------------------------------------------------
   // Acceptance: a beat is taken at a rising edge with start high, busy low.
   // The prediction is made here so it follows accept order exactly.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      window_beat_type b;
      if (!reset && start && !busy) begin
         b.op    = op_type'(req_op);
         b.port  = port_type'(req_port_offset);
         b.wdata = req_wdata;
         b.alt   = req_a20_alt_now;
         expected_results.push_back(shadow_window_predict(b));
         beats_accepted <= beats_accepted + 1;
         beat_taken     <= 1'b1;
      end else begin
         beat_taken <= 1'b0;
      end
   end

   // --------------------------------------------------------------------------
   // Driver: changes inputs on the falling edge. A beat stays up until taken;
   // after that the next one goes out unless this cycle is picked as idle.
   // start is assigned once per falling edge, so back-to-back beats keep it high.
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      window_beat_type b;
      if (!reset && (!start || beat_taken)) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
            b = pending_beats.pop_front();
            start           <= 1'b1;
            req_op          <= b.op;
            req_port_offset <= b.port;
            req_wdata       <= b.wdata;
            req_a20_alt_now <= b.alt;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string field_name, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h (cycle %0d)",
                     field_name, want, got, cycle_count);
         mismatch_count++;
      end
   endtask

   // --------------------------------------------------------------------------
   // Monitor: every strobed result is matched with the oldest prediction.
   // The receiver cannot stall, so there is nothing to drive on this side.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      window_result_type exp_res;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("unexpected result beat, rdata %h (cycle %0d)",
                        rsp_rdata, cycle_count);
            mismatch_count++;
         end else begin
            exp_res = expected_results.pop_front();
            check_field("rdata",             exp_res.rdata,   rsp_rdata);
            check_field("int_read_mask",     exp_res.rd_mask, rsp_int_read_mask);
            check_field("int_write_mask",    exp_res.wr_mask, rsp_int_write_mask);
            check_field("bios_shadow_read",  exp_res.bios_rd, rsp_bios_shadow_read);
            check_field("bios_shadow_write", exp_res.bios_wr, rsp_bios_shadow_write);
            check_field("a20_enable_req",    exp_res.a20_en,  rsp_a20_enable_req);
            check_field("a20_disable_req",   exp_res.a20_dis, rsp_a20_disable_req);
            check_field("cpu_reset_req",     exp_res.cpu_rst, rsp_cpu_reset_req);
         end
      end
   end

   task automatic push_beat(input op_type op, input port_type port,
                            input logic [7:0] wdata, input logic alt);
      pending_beats.push_back('{op: op, port: port, wdata: wdata, alt: alt});
      beats_queued++;
   endtask

   // index choice leans on the writable file and the shadow registers, with
   // some hits on register 0, just past the file and anywhere in the byte
   function automatic logic [7:0] pick_index();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         return 8'($urandom_range(REG_LAST, REG_CFG1));
      else if (r < 78)
         return 8'($urandom_range(SHADOW_LAST, SHADOW_FIRST));
      else if (r < 88)
         return ($urandom_range(1) != 0) ? REG_ID
                                         : 8'($urandom_range(REG_PAST + 3, REG_PAST));
      else
         return 8'($urandom_range(255));
   endfunction

   // mostly index-then-data sequences; the rest is single accesses and noise
   task automatic queue_random_session(input int n);
      int r;
      int start_count;
      int data_run;
      start_count = beats_queued;
      while (beats_queued - start_count < n) begin
         r = $urandom_range(99);
         if (r < 50) begin
            push_beat(OP_WRITE, PORT_INDEX, pick_index(), 1'($urandom_range(1)));
            data_run = $urandom_range(3, 1);
            for (int i = 0; i < data_run; i++)
               push_beat(op_type'($urandom_range(1)), PORT_DATA, 8'($urandom_range(255)),
                         1'($urandom_range(1)));
         end else if (r < 62) begin
            push_beat(OP_READ, PORT_INDEX, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (r < 76) begin
            push_beat(op_type'($urandom_range(1)), PORT_A20, 8'($urandom_range(255)),
                      1'($urandom_range(1)));
         end else if (r < 84) begin
            push_beat(op_type'($urandom_range(1)), PORT_RESET, 8'($urandom_range(255)),
                      1'($urandom_range(1)));
         end else begin
            push_beat(op_type'($urandom_range(1)), port_type'($urandom_range(3)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_op          = OP_READ;
      req_port_offset = PORT_INDEX;
      req_wdata       = 8'h00;
      req_a20_alt_now = 1'b0;

      // power-on view of the window
      chip_index = 8'h00;
      for (int i = 0; i <= LAST_WRITABLE; i++)
         chip_regs[i] = 8'h00;
      chip_regs[REG_ID]   = 8'h90;
      chip_regs[REG_CFG1] = 8'hff;
      chip_regs[REG_CFG2] = 8'h8a;
      chip_regs[REG_CFG3] = 8'h88;
      chip_regs[REG_CFG6] = 8'h1b;
      chip_regs[REG_CFG8] = 8'h38;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset contents, read-only register 0, sticky bit of
      // register 5, last writable register, index past the file, shadow
      // decode including the BIOS segments, A20 and reset port pulses
      push_beat(OP_READ,  PORT_INDEX, 8'h00, 1'b0);
      push_beat(OP_READ,  PORT_DATA,  8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_DATA,  8'h55, 1'b0);
      push_beat(OP_READ,  PORT_DATA,  8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_INDEX, REG_CFG1, 1'b0);
      push_beat(OP_READ,  PORT_DATA,  8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_INDEX, REG_MASKED, 1'b0);
      push_beat(OP_WRITE, PORT_DATA,  8'hff, 1'b0);
      push_beat(OP_READ,  PORT_DATA,  8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_INDEX, REG_LAST, 1'b0);
      push_beat(OP_WRITE, PORT_DATA,  8'ha5, 1'b1);
      push_beat(OP_READ,  PORT_DATA,  8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_INDEX, REG_PAST, 1'b0);
      push_beat(OP_WRITE, PORT_DATA,  8'h3c, 1'b0);
      push_beat(OP_READ,  PORT_DATA,  8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_INDEX, REG_TOP, 1'b0);
      push_beat(OP_READ,  PORT_INDEX, 8'h00, 1'b0);
      push_beat(OP_READ,  PORT_DATA,  8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_INDEX, SHADOW_LAST, 1'b0);
      push_beat(OP_WRITE, PORT_DATA,  8'hff, 1'b0);
      push_beat(OP_WRITE, PORT_INDEX, SHADOW_FIRST, 1'b0);
      push_beat(OP_WRITE, PORT_DATA,  8'h9c, 1'b0);
      push_beat(OP_READ,  PORT_A20,   8'h00, 1'b0);
      push_beat(OP_READ,  PORT_A20,   8'h00, 1'b1);
      push_beat(OP_WRITE, PORT_A20,   8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_A20,   8'hff, 1'b1);
      push_beat(OP_READ,  PORT_RESET, 8'h00, 1'b0);
      push_beat(OP_WRITE, PORT_RESET, 8'hff, 1'b1);

      // three idling phases: light sender gaps, heavy gaps, none
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 14 : (phase == 1) ? 86 : 0;
         queue_random_session(RANDOM_BEATS);
         while (beats_accepted < beats_queued || expected_results.size() != 0)
            @(negedge clock);
      end

      // let any late or stray result beat show up
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("chipset_index_regs_shadow_ctrl regression: pass");
      else
         $display("chipset_index_regs_shadow_ctrl regression: fail");
      $finish;
   end

endmodule
